// ===== src/pip_pkg.sv =====
// Shared types and constants for the phase interval profiler.
package pip_pkg;

    localparam int PHASE_BITS_DEF = 8;
    localparam int CODE_W         = 8;
    localparam int TIME_W         = 64;
    localparam int COUNT_W        = 32;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT = '1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [CODE_W-1:0] phase_code;
        logic [TIME_W-1:0] event_time;
    } event_t;

    typedef struct packed {
        logic [CODE_W-1:0]  closed_phase;
        logic [TIME_W-1:0]  interval;
        logic [COUNT_W-1:0] pair_count;
        logic [TIME_W-1:0]  total_time;
        logic [TIME_W-1:0]  min_interval;
        logic [TIME_W-1:0]  max_interval;
    } result_t;

    // Classified event as it travels from the front to the back.
    typedef struct packed {
        logic              is_end;
        logic [CODE_W-1:0] phase_code;
        logic [TIME_W-1:0] event_time;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_link_t;

    typedef struct packed {
        logic take;
        logic clearing;
    } back_status_t;

    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] start_time;
    } pend_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  total;
        logic [TIME_W-1:0]  min;
        logic [TIME_W-1:0]  max;
    } stats_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_WRITE
    } back_state_t;

endpackage

// ===== src/pip_front.sv =====
// Front end: accepts trace events, classifies them and queues them for the back end.
module pip_front #(
    parameter int PHASE_BITS = pip_pkg::PHASE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  pip_pkg::event_t       trace_event,
    output pip_pkg::cmd_link_t    link,
    input  pip_pkg::back_status_t status
);

    localparam int CODE_W = pip_pkg::CODE_W;
    localparam int QPTR_W = pip_pkg::QPTR_W;
    localparam int QCNT_W = pip_pkg::QCNT_W;

    pip_pkg::cmd_t q_mem [pip_pkg::QUEUE_DEPTH];

    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    logic [PHASE_BITS-1:0] code_ext;
    pip_pkg::cmd_t         new_cmd;
    logic                  accept;
    logic                  take;

    // Code bits above the configured phase width are dropped here.
    always_comb
    begin
        code_ext           = PHASE_BITS'(trace_event.phase_code);
        new_cmd.phase_code = CODE_W'(code_ext);
        new_cmd.is_end     = code_ext[0];
        new_cmd.event_time = trace_event.event_time;
    end

    assign full   = (count_reg == QCNT_W'(pip_pkg::QUEUE_DEPTH)) || status.clearing;
    assign accept = push && !full;
    assign take   = status.take && (count_reg != '0);

    assign link.valid = (count_reg != '0);
    assign link.cmd   = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (accept)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(pip_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : wr_ptr_reg + 1'b1;
        end
        if (take)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(pip_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : rd_ptr_reg + 1'b1;
        end
        if (accept && !take)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (take && !accept)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_mem[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

// ===== src/pip_back.sv =====
// Back end: per-phase pending and statistics memories, update sequencer and result register.
module pip_back #(
    parameter int PHASE_BITS = pip_pkg::PHASE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pip_pkg::cmd_link_t    link,
    output pip_pkg::back_status_t status,
    input  logic                  pop,
    output logic                  res_valid,
    output pip_pkg::result_t      result
);

    localparam int SLOT_W = PHASE_BITS - 1;
    localparam int SLOTS  = 1 << SLOT_W;
    localparam int TIME_W = pip_pkg::TIME_W;

    pip_pkg::pend_t  pend_mem  [SLOTS];
    pip_pkg::stats_t stats_mem [SLOTS];
    pip_pkg::pend_t  pend_rd_reg;
    pip_pkg::stats_t stats_rd_reg;

    pip_pkg::back_state_t state_reg, state_next;
    logic [SLOT_W-1:0]    clr_addr_reg, clr_addr_next;
    pip_pkg::cmd_t        cmd_reg, cmd_next;
    logic [TIME_W-1:0]    dur_reg, dur_next;
    pip_pkg::stats_t      upd_reg, upd_next;
    pip_pkg::result_t     res_reg, res_next;
    logic                 res_valid_reg, res_valid_next;

    logic [PHASE_BITS-1:0] head_code_ext;
    logic [PHASE_BITS-1:0] cmd_code_ext;
    logic [SLOT_W-1:0]     head_slot;
    logic [SLOT_W-1:0]     cmd_slot;
    logic [SLOT_W-1:0]     mem_addr;
    logic                  take;
    logic                  rd_en;
    logic                  pend_we;
    logic                  stats_we;
    logic                  commit;
    logic                  pop_ok;
    pip_pkg::pend_t        pend_wdata;
    pip_pkg::stats_t       stats_wdata;
    pip_pkg::stats_t       calc;

    assign head_code_ext = PHASE_BITS'(link.cmd.phase_code);
    assign cmd_code_ext  = PHASE_BITS'(cmd_reg.phase_code);
    assign head_slot     = head_code_ext[PHASE_BITS-1:1];
    assign cmd_slot      = cmd_code_ext[PHASE_BITS-1:1];
    assign pop_ok        = pop && res_valid_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pip_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == SLOT_W'(SLOTS - 1))
                begin
                    state_next = pip_pkg::ST_IDLE;
                end
            end
            pip_pkg::ST_IDLE:
            begin
                if (link.valid && link.cmd.is_end)
                begin
                    state_next = pip_pkg::ST_READ;
                end
            end
            pip_pkg::ST_READ:
            begin
                state_next = pend_rd_reg.valid ? pip_pkg::ST_CALC : pip_pkg::ST_IDLE;
            end
            pip_pkg::ST_CALC:
            begin
                state_next = pip_pkg::ST_WRITE;
            end
            pip_pkg::ST_WRITE:
            begin
                if (!res_valid_reg || pop_ok)
                begin
                    state_next = pip_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pip_pkg::ST_IDLE;
            end
        endcase
    end

    // Control outputs per state.
    always_comb
    begin
        take        = 1'b0;
        rd_en       = 1'b0;
        pend_we     = 1'b0;
        stats_we    = 1'b0;
        commit      = 1'b0;
        mem_addr    = cmd_slot;
        pend_wdata  = '0;
        stats_wdata = upd_reg;
        status.clearing = 1'b0;
        case (state_reg)
            pip_pkg::ST_CLEAR:
            begin
                status.clearing = 1'b1;
                pend_we         = 1'b1;
                stats_we        = 1'b1;
                mem_addr        = clr_addr_reg;
                stats_wdata     = '0;
            end
            pip_pkg::ST_IDLE:
            begin
                take     = link.valid;
                mem_addr = head_slot;
                if (link.valid)
                begin
                    if (link.cmd.is_end)
                    begin
                        rd_en = 1'b1;
                    end
                    else
                    begin
                        pend_we                = 1'b1;
                        pend_wdata.valid       = 1'b1;
                        pend_wdata.start_time  = link.cmd.event_time;
                    end
                end
            end
            pip_pkg::ST_WRITE:
            begin
                if (!res_valid_reg || pop_ok)
                begin
                    commit   = 1'b1;
                    pend_we  = 1'b1;
                    stats_we = 1'b1;
                end
            end
            default:
            begin
                take = 1'b0;
            end
        endcase
        status.take = take;
    end

    // Statistics update for one matched interval.
    always_comb
    begin
        calc.count = (stats_rd_reg.count == pip_pkg::COUNT_LIMIT) ? stats_rd_reg.count
                                                                  : stats_rd_reg.count + 1'b1;
        calc.total = stats_rd_reg.total + dur_reg;
        // A zero count marks the first interval, so a never-written minimum is not used.
        calc.min   = ((stats_rd_reg.count == '0) || (dur_reg < stats_rd_reg.min)) ? dur_reg
                                                                                : stats_rd_reg.min;
        calc.max   = (dur_reg > stats_rd_reg.max) ? dur_reg : stats_rd_reg.max;
    end

    always_comb
    begin
        clr_addr_next  = (state_reg == pip_pkg::ST_CLEAR) ? clr_addr_reg + 1'b1 : clr_addr_reg;
        cmd_next       = take ? link.cmd : cmd_reg;
        dur_next       = (state_reg == pip_pkg::ST_READ)
                         ? cmd_reg.event_time - pend_rd_reg.start_time : dur_reg;
        upd_next       = (state_reg == pip_pkg::ST_CALC) ? calc : upd_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !pop_ok;
        if (commit)
        begin
            res_valid_next        = 1'b1;
            res_next.closed_phase = {cmd_reg.phase_code[pip_pkg::CODE_W-1:1], 1'b0};
            res_next.interval     = dur_reg;
            res_next.pair_count   = upd_reg.count;
            res_next.total_time   = upd_reg.total;
            res_next.min_interval = upd_reg.min;
            res_next.max_interval = upd_reg.max;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pip_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        dur_reg <= dur_next;
        upd_reg <= upd_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (pend_we)
        begin
            pend_mem[mem_addr] <= pend_wdata;
        end
        if (rd_en)
        begin
            pend_rd_reg <= pend_mem[mem_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stats_we)
        begin
            stats_mem[mem_addr] <= stats_wdata;
        end
        if (rd_en)
        begin
            stats_rd_reg <= stats_mem[mem_addr];
        end
    end

    assign res_valid = res_valid_reg;
    assign result    = res_reg;

endmodule

// ===== src/phase_interval_profiler.sv =====
// Top level of the phase interval profiler.
// Trace events enter through a queue-style push/full port and are classified by a front end
// into a two-entry queue; a back end sequencer applies them to per-phase memories and hands
// each matched interval's statistics to a one-entry result register read through empty/pop.
// The front takes one event per cycle while its queue has room. The back end, which sets the
// sustained rate, passes a start event through idle, an end with no pending start through
// idle and read, and a matched end through idle, read, calc and write (memory read, duration,
// statistics update, write-back), plus any time spent waiting for the previous result to be
// popped. After reset, full stays high while a clearing pass zeroes the per-phase memories.
module phase_interval_profiler #(
    parameter int PHASE_BITS = pip_pkg::PHASE_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  pip_pkg::event_t  trace_event,
    output logic             empty,
    input  logic             pop,
    output pip_pkg::result_t result
);

    pip_pkg::cmd_link_t    link;
    pip_pkg::back_status_t status;
    logic                  res_valid;

    pip_front #(
        .PHASE_BITS (PHASE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .trace_event (trace_event),
        .link        (link),
        .status      (status)
    );

    pip_back #(
        .PHASE_BITS (PHASE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .link      (link),
        .status    (status),
        .pop       (pop),
        .res_valid (res_valid),
        .result    (result)
    );

    assign empty = !res_valid;

endmodule

// ===== src/pip_checker.sv =====
// Port-level checks for the phase interval profiler and their binding to the top level.
module pip_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             empty,
    input logic             pop,
    input pip_pkg::result_t result
);

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed before it was popped");

    a_even_phase: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !result.closed_phase[0])
        else $error("result names an odd phase code");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.pair_count != '0))
        else $error("result carries a zero pair count");

    a_interval_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((result.min_interval <= result.interval) &&
                    (result.interval <= result.max_interval)))
        else $error("interval lies outside the reported minimum and maximum");

endmodule

bind phase_interval_profiler pip_checker u_pip_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the phase interval profiler: scoreboard class and top module.
`timescale 1ns / 1ps

localparam int PROF_PHASE_BITS = pip_pkg::PHASE_BITS_DEF;
localparam int PROF_SLOT_W     = PROF_PHASE_BITS - 1;
localparam int PROF_SLOTS      = 1 << PROF_SLOT_W;

typedef logic [PROF_SLOT_W-1:0] slot_idx_t;

class interval_scoreboard;
    logic [pip_pkg::TIME_W-1:0]  open_start [PROF_SLOTS];
    bit                          open_valid [PROF_SLOTS];
    logic [pip_pkg::COUNT_W-1:0] pair_cnt   [PROF_SLOTS];
    logic [pip_pkg::TIME_W-1:0]  sum_time   [PROF_SLOTS];
    logic [pip_pkg::TIME_W-1:0]  shortest   [PROF_SLOTS];
    logic [pip_pkg::TIME_W-1:0]  longest    [PROF_SLOTS];

    pip_pkg::result_t expected_stats[$];

    int unsigned starts;
    int unsigned matched;
    int unsigned unmatched;
    int unsigned checked;
    int unsigned mismatches;

    function new();
        for (int i = 0; i < PROF_SLOTS; i++)
        begin
            open_start[i] = '0;
            open_valid[i] = 1'b0;
            pair_cnt[i]   = '0;
            sum_time[i]   = '0;
            shortest[i]   = '0;
            longest[i]    = '0;
        end
        starts     = 0;
        matched    = 0;
        unmatched  = 0;
        checked    = 0;
        mismatches = 0;
    endfunction

    // Returns 1 when the event changes state, 0 when the block ignores it.
    function bit note_event(pip_pkg::event_t ev);
        logic [pip_pkg::CODE_W-1:0] code;
        slot_idx_t                  slot;
        logic [pip_pkg::TIME_W-1:0] dur;
        pip_pkg::result_t           exp;
        code = ev.phase_code & pip_pkg::CODE_W'((1 << PROF_PHASE_BITS) - 1);
        slot = slot_idx_t'(code >> 1);
        if (!code[0])
        begin
            open_start[slot] = ev.event_time;
            open_valid[slot] = 1'b1;
            starts++;
            return 1'b1;
        end
        if (!open_valid[slot])
        begin
            unmatched++;
            return 1'b0;
        end
        open_valid[slot] = 1'b0;
        dur = ev.event_time - open_start[slot];
        // The first interval of a phase always sets the minimum.
        if (pair_cnt[slot] == '0 || dur < shortest[slot])
            shortest[slot] = dur;
        if (pair_cnt[slot] != pip_pkg::COUNT_LIMIT)
            pair_cnt[slot] = pair_cnt[slot] + 1'b1;
        sum_time[slot] = sum_time[slot] + dur;
        if (dur > longest[slot])
            longest[slot] = dur;
        exp.closed_phase = code - 1'b1;
        exp.interval     = dur;
        exp.pair_count   = pair_cnt[slot];
        exp.total_time   = sum_time[slot];
        exp.min_interval = shortest[slot];
        exp.max_interval = longest[slot];
        expected_stats.push_back(exp);
        matched++;
        return 1'b1;
    endfunction

    function void check_result(pip_pkg::result_t got);
        pip_pkg::result_t exp;
        bit               bad;
        checked++;
        if (expected_stats.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("Unexpected result: phase %0d interval %0h count %0d",
                         got.closed_phase, got.interval, got.pair_count);
            return;
        end
        exp = expected_stats.pop_front();
        bad = (got.closed_phase !== exp.closed_phase) || (got.interval !== exp.interval) ||
              (got.pair_count !== exp.pair_count) || (got.total_time !== exp.total_time) ||
              (got.min_interval !== exp.min_interval) ||
              (got.max_interval !== exp.max_interval);
        if (bad)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("Mismatch expected: phase %0d ivl %0h cnt %0d tot %0h min %0h max %0h",
                         exp.closed_phase, exp.interval, exp.pair_count, exp.total_time,
                         exp.min_interval, exp.max_interval);
                $display("         actual:   phase %0d ivl %0h cnt %0d tot %0h min %0h max %0h",
                         got.closed_phase, got.interval, got.pair_count, got.total_time,
                         got.min_interval, got.max_interval);
            end
        end
    endfunction

    function int outstanding();
        return expected_stats.size();
    endfunction
endclass

module tb_top;

    localparam int          USEFUL_ITEMS = 1500;
    localparam int          TAIL_START   = 1250;
    localparam int          DRAIN_PAUSE  = 800;
    localparam int          HOLD_AFTER   = 150;
    localparam int          HOLD_CYCLES  = 300;
    localparam int unsigned CYCLE_LIMIT  = 250000;
    localparam logic [pip_pkg::TIME_W-1:0] TIME_MAX = '1;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             push = 1'b0;
    logic             full;
    pip_pkg::event_t  trace_event = '0;
    logic             empty;
    logic             pop = 1'b0;
    pip_pkg::result_t result;

    interval_scoreboard sb = new();

    int unsigned cycle_cnt = 0;
    int          pop_stall_left = 0;
    bit          hold_done = 1'b0;
    bit          quiet_tail = 1'b0;
    int          useful = 0;
    logic [pip_pkg::TIME_W-1:0] ts_now = '0;

    phase_interval_profiler dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .trace_event (trace_event),
        .empty       (empty),
        .pop         (pop),
        .result      (result)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // Result side: check every popped transaction, then pick pop for the next cycle.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
                sb.check_result(result);
            if (pop_stall_left > 0)
            begin
                pop_stall_left--;
                pop <= 1'b0;
            end
            else if (!hold_done && sb.checked >= HOLD_AFTER)
            begin
                // Long hold-off so the internal queue fills and full asserts.
                hold_done = 1'b1;
                pop_stall_left = HOLD_CYCLES - 1;
                pop <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 9) == 0)
            begin
                pop_stall_left = $urandom_range(0, 5);
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // Offers one event and returns on the edge that accepts it.
    task automatic send_event(input logic [pip_pkg::CODE_W-1:0] code,
                              input logic [pip_pkg::TIME_W-1:0] ts);
        pip_pkg::event_t ev;
        ev.phase_code = code;
        ev.event_time = ts;
        trace_event <= ev;
        push <= 1'b1;
        do
            @(posedge clk);
        while (full);
        if (sb.note_event(ev))
            useful++;
    endtask

    task automatic sender_gap();
        if (!quiet_tail && $urandom_range(0, 7) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic send_random_event();
        slot_idx_t                  slot;
        logic [pip_pkg::CODE_W-1:0] code;
        logic [pip_pkg::TIME_W-1:0] ts;
        bit                         is_end;
        ts_now = ts_now + pip_pkg::TIME_W'($urandom_range(0, 40));
        if ($urandom_range(0, 199) == 0)
            ts_now = {$urandom, $urandom};
        ts = ts_now;
        if ($urandom_range(0, 19) == 0)
            ts = {$urandom, $urandom};
        if ($urandom_range(0, 9) == 0)
        begin
            // Noise: any code at all, mostly unmatched ends and stray restarts.
            code = pip_pkg::CODE_W'($urandom_range(0, 255));
        end
        else
        begin
            if ($urandom_range(0, 3) == 0)
                slot = slot_idx_t'($urandom_range(0, PROF_SLOTS - 1));
            else
                slot = slot_idx_t'($urandom_range(0, 7));
            if (sb.open_valid[slot])
                is_end = ($urandom_range(0, 99) < 85);
            else
                is_end = ($urandom_range(0, 99) < 15);
            code = pip_pkg::CODE_W'({slot, is_end});
        end
        send_event(code, ts);
    endtask

    initial
    begin
        bit drained;
        drained = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed events.
        send_event(8'd0, 64'd0);
        send_event(8'd1, 64'd0);
        send_event(8'd0, 64'd10);
        send_event(8'd1, 64'd15);
        send_event(8'd254, TIME_MAX);
        send_event(8'd255, 64'd0);
        send_event(8'd3, 64'd77);
        send_event(8'd2, 64'd100);
        send_event(8'd2, 64'd200);
        send_event(8'd3, 64'd250);
        send_event(8'd3, 64'd300);
        send_event(8'd4, 64'd0);
        send_event(8'd5, TIME_MAX);
        send_event(8'd6, 64'd1000);
        send_event(8'd7, 64'd10);
        // Total for this phase wraps through zero here.
        send_event(8'd4, 64'd5);
        send_event(8'd5, 64'd6);
        send_event(8'd128, 64'h8000_0000_0000_0000);
        send_event(8'd129, 64'h8000_0000_0000_0007);
        send_event(8'd170, 64'h5555_5555_5555_5555);
        send_event(8'd171, 64'hAAAA_AAAA_AAAA_AAAA);
        ts_now = 64'd5000;

        while (useful < USEFUL_ITEMS)
        begin
            if (useful >= TAIL_START)
                quiet_tail = 1'b1;
            sender_gap();
            if (!drained && useful >= DRAIN_PAUSE)
            begin
                drained = 1'b1;
                push <= 1'b0;
                while (sb.outstanding() != 0)
                    @(posedge clk);
            end
            send_random_event();
        end
        push <= 1'b0;

        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("Sent %0d starts, %0d matched ends and %0d unmatched ends;",
                 sb.starts, sb.matched, sb.unmatched);
        $display("checked %0d statistics transactions, %0d mismatches, %0d left over.",
                 sb.checked, sb.mismatches, sb.outstanding());
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
